/* design/rtcm3_frame_sync_crc_check_macros.svh */
// Assertion macros for the RTCM 3 frame sync block.
// Expects clk_i and rst_ni in the scope where the macros are used.
`ifndef RTCM3_FRAME_SYNC_CRC_CHECK_MACROS_SVH
`define RTCM3_FRAME_SYNC_CRC_CHECK_MACROS_SVH

// Plain property, sampled on the rising clock, off during reset.
`define RTCM3_FSC_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) else $error(msg);

// Same-cycle implication.
`define RTCM3_FSC_ASSERT_IMP(lbl, ante, cons, msg) \
  `RTCM3_FSC_ASSERT(lbl, (ante) |-> (cons), msg)

// Next-cycle implication.
`define RTCM3_FSC_ASSERT_NXT(lbl, ante, cons, msg) \
  `RTCM3_FSC_ASSERT(lbl, (ante) |=> (cons), msg)

`endif

/* design/rtcm3_fsc_pkg.sv */
// Shared types and constants for the RTCM 3 frame sync / CRC-24Q checker.
// No dependencies.
`timescale 1ns / 1ps

package rtcm3_fsc_pkg;

  localparam int unsigned CrcW    = 24;
  localparam int unsigned ByteW   = 8;
  localparam int unsigned LenW    = 10;
  localparam int unsigned CntW    = 11;
  localparam int unsigned TypeW   = 12;

  localparam logic [ByteW-1:0] Preamble = 8'hD3;
  // CRC-24Q polynomial without the x^24 term
  localparam logic [CrcW-1:0]  CrcPoly  = 24'h864CFB;
  // shortest payload the header may announce is one more than this
  localparam logic [LenW-1:0]  MinLen   = 10'd4;
  // three CRC bytes follow the payload
  localparam logic [CntW-1:0]  CrcBytes = 11'd3;

  typedef enum logic [3:0] {
    PH_HUNT = 4'b0001,
    PH_HDR1 = 4'b0010,
    PH_HDR2 = 4'b0100,
    PH_BODY = 4'b1000
  } phase_e;

  typedef struct packed {
    logic             frame_valid;
    logic             crc_fail;
    logic [TypeW-1:0] message_type;
    logic [LenW-1:0]  payload_length;
  } fsc_result_t;

endpackage

/* design/rtcm3_frame_sync_crc_check.sv */
// RTCM 3 frame synchronizer with CRC-24Q check, top level.
// Uses rtcm3_fsc_pkg, rtcm3_fsc_fsm and the assertion macro header.
//
// Usage:
//  - Slave stream carries one received byte per item on s_axis_tdata_i.
//  - The block hunts for preamble 0xD3, checks the two header bytes
//    (6 reserved bits zero, 10-bit length > 4), runs CRC-24Q over preamble,
//    header and payload, then compares with the three trailing CRC bytes.
//  - Every input item yields exactly one output item. tuser flags a good
//    frame (bit 0) or a CRC error (bit 1) on the last CRC byte; all other
//    items come out all zero. tdata carries message type and length of a
//    good frame.
//  - Throughput: one item per cycle unless the master stalls. Two stages:
//    an accepted byte goes to the input register, its result to the result
//    register that drives the master side, with the hunt/CRC FSM and one
//    byte-wide CRC update in between.
//  - Master stall: the result register holds; the input register still
//    takes one more item, after which s_axis_tready_o drops until the
//    result is taken.
//  - Reset (rst_ni low, async) empties both stages and returns to hunting.
`timescale 1ns / 1ps

`include "rtcm3_frame_sync_crc_check_macros.svh"

module rtcm3_frame_sync_crc_check import rtcm3_fsc_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  // byte stream in
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  input  logic [7:0]  s_axis_tdata_i,   // [7:0] rx_byte
  // results out
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  output logic [23:0] m_axis_tdata_o,   // [11:0] message_type, [21:12] payload_length,
                                        // [23:22] zero
  output logic [1:0]  m_axis_tuser_o    // [0] frame_valid, [1] crc_fail
);

  logic             in_valid_q;
  logic [ByteW-1:0] in_byte_q;
  logic             out_valid_q;
  fsc_result_t      out_res_q;
  fsc_result_t      fsm_res;
  logic             adv;
  logic             step;

  // result stage can move when empty or being drained
  assign adv             = !out_valid_q || m_axis_tready_i;
  assign s_axis_tready_o = !in_valid_q || adv;
  assign step            = adv && in_valid_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (s_axis_tready_o) begin
      in_valid_q <= s_axis_tvalid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tready_o && s_axis_tvalid_i) begin
      in_byte_q <= s_axis_tdata_i;
    end
  end

  rtcm3_fsc_fsm u_fsm (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .step_i (step),
    .byte_i (in_byte_q),
    .res_o  (fsm_res)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (adv) begin
      out_valid_q <= in_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (step) begin
      out_res_q <= fsm_res;
    end
  end

  assign m_axis_tvalid_o = out_valid_q;
  assign m_axis_tdata_o  = {2'b00, out_res_q.payload_length, out_res_q.message_type};
  assign m_axis_tuser_o  = {out_res_q.crc_fail, out_res_q.frame_valid};

  // ---------------------------------------------------------------------
  // Assertions
  // ---------------------------------------------------------------------
  `RTCM3_FSC_ASSERT_NXT(a_stage_moves, step, out_valid_q, "item lost between stages")
  `RTCM3_FSC_ASSERT_IMP(a_ready_on_drain, adv, s_axis_tready_o, "input stalled while result drains")
  `RTCM3_FSC_ASSERT(a_flags_excl, !(out_valid_q && out_res_q.frame_valid && out_res_q.crc_fail), "both result flags set")
  `RTCM3_FSC_ASSERT_IMP(a_len_ok, out_valid_q && out_res_q.frame_valid, out_res_q.payload_length > MinLen, "good frame with short length")
  `RTCM3_FSC_ASSERT_IMP(a_zero_data, out_valid_q && !out_res_q.frame_valid, m_axis_tdata_o == '0, "data set without good frame")

endmodule

/* design/rtcm3_fsc_crc.sv */
// Byte-wide CRC-24Q update (MSB first, no reflection).
// Uses rtcm3_fsc_pkg.
`timescale 1ns / 1ps

module rtcm3_fsc_crc import rtcm3_fsc_pkg::*; (
  input  logic [CrcW-1:0]  crc_i,
  input  logic [ByteW-1:0] byte_i,
  output logic [CrcW-1:0]  crc_o
);

  always_comb begin
    logic [CrcW-1:0] c;
    logic            msb;
    c = crc_i ^ {byte_i, {(CrcW-ByteW){1'b0}}};
    for (int i = 0; i < ByteW; i++) begin
      msb = c[CrcW-1];
      c   = {c[CrcW-2:0], 1'b0};
      if (msb) begin
        c = c ^ CrcPoly;
      end
    end
    crc_o = c;
  end

endmodule

/* design/rtcm3_fsc_fsm.sv */
// Frame hunt / header check / payload and CRC tracking state machine.
// Uses rtcm3_fsc_pkg and rtcm3_fsc_crc.
`timescale 1ns / 1ps

module rtcm3_fsc_fsm import rtcm3_fsc_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              step_i,
  input  logic [ByteW-1:0]  byte_i,
  output fsc_result_t       res_o
);

  phase_e           phase_q, phase_d;
  logic [LenW-1:0]  flen_q, flen_d;
  logic [CntW-1:0]  cnt_q, cnt_d;
  logic [CrcW-1:0]  crc_q, crc_d;
  logic [CrcW-1:0]  rcv_q, rcv_d;
  logic [TypeW-1:0] type_q, type_d;

  logic [CrcW-1:0]  crc_in;
  logic [CrcW-1:0]  crc_upd;
  logic [LenW-1:0]  hdr_len;
  logic [CntW-1:0]  cnt_inc;
  logic [CntW-1:0]  frame_end;

  // new frame starts the CRC from zero
  assign crc_in = (phase_q == PH_HUNT) ? '0 : crc_q;

  rtcm3_fsc_crc u_crc (
    .crc_i  (crc_in),
    .byte_i (byte_i),
    .crc_o  (crc_upd)
  );

  assign hdr_len   = {flen_q[1:0], byte_i};
  assign cnt_inc   = cnt_q + 11'd1;
  assign frame_end = {1'b0, flen_q} + CrcBytes;

  always_comb begin
    phase_d = phase_q;
    flen_d  = flen_q;
    cnt_d   = cnt_q;
    crc_d   = crc_q;
    rcv_d   = rcv_q;
    type_d  = type_q;
    res_o   = '0;
    case (phase_q)
      PH_HUNT: begin
        if (byte_i == Preamble) begin
          crc_d   = crc_upd;
          cnt_d   = '0;
          rcv_d   = '0;
          type_d  = '0;
          flen_d  = '0;
          phase_d = PH_HDR1;
        end
      end
      PH_HDR1: begin
        crc_d   = crc_upd;
        flen_d  = {{(LenW-ByteW){1'b0}}, byte_i};
        phase_d = PH_HDR2;
      end
      PH_HDR2: begin
        crc_d   = crc_upd;
        flen_d  = hdr_len;
        cnt_d   = '0;
        // reserved bits set or payload too short: back to hunting
        if ((flen_q[7:2] != '0) || (hdr_len <= MinLen)) begin
          phase_d = PH_HUNT;
        end else begin
          phase_d = PH_BODY;
        end
      end
      PH_BODY: begin
        if (cnt_q < {1'b0, flen_q}) begin
          crc_d = crc_upd;
          if (cnt_q == '0) begin
            type_d = {byte_i, 4'h0};
          end else if (cnt_q == 11'd1) begin
            type_d = {type_q[TypeW-1:4], byte_i[7:4]};
          end
        end else begin
          rcv_d = {rcv_q[CrcW-ByteW-1:0], byte_i};
        end
        cnt_d = cnt_inc;
        if (cnt_inc >= frame_end) begin
          if (crc_d == rcv_d) begin
            res_o.frame_valid    = 1'b1;
            res_o.message_type   = type_d;
            res_o.payload_length = flen_q;
          end else begin
            res_o.crc_fail = 1'b1;
          end
          phase_d = PH_HUNT;
          cnt_d   = '0;
        end
      end
      default: begin
        phase_d = PH_HUNT;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q <= PH_HUNT;
      flen_q  <= '0;
      cnt_q   <= '0;
      crc_q   <= '0;
      rcv_q   <= '0;
      type_q  <= '0;
    end else if (step_i) begin
      phase_q <= phase_d;
      flen_q  <= flen_d;
      cnt_q   <= cnt_d;
      crc_q   <= crc_d;
      rcv_q   <= rcv_d;
      type_q  <= type_d;
    end
  end

endmodule
